[rtl/metropolis_particle_walk_1d_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the 1-D Metropolis particle walk.
// Each macro expects signals named clk and rst in the scope that uses it.
// ---------------------------------------------------------------------------
`ifndef METROPOLIS_PARTICLE_WALK_1D_DEFINES_SVH
`define METROPOLIS_PARTICLE_WALK_1D_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define MPW1D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds across reset.
`define MPW1D_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPW1D_ASSERT(label, prop, msg)
`define MPW1D_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/mpw1d_pkg.sv]
// ---------------------------------------------------------------------------
// mpw1d_pkg
// Shared constants and the acceptance table recurrence of the particle walk.
// ---------------------------------------------------------------------------
`default_nettype none

package mpw1d_pkg;

  // Default sizes of the stores and the acceptance table.
  localparam int LANDSCAPE_DEPTH_DEF = 65536;
  localparam int PARTICLE_COUNT_DEF  = 1024;
  localparam int ENERGY_WIDTH_DEF    = 16;
  localparam int EXP_TABLE_DEPTH_DEF = 1024;

  // Command codes.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PLACE = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEFT_EDGE    = 2'd0;
  localparam logic [1:0] REG_LEFT_TARGET  = 2'd1;
  localparam logic [1:0] REG_RIGHT_EDGE   = 2'd2;
  localparam logic [1:0] REG_RIGHT_TARGET = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] LEFT_EDGE_RST    = 16'd0;
  localparam logic [15:0] LEFT_TARGET_RST  = 16'd1;
  localparam logic [15:0] RIGHT_EDGE_RST   = 16'd65535;
  localparam logic [15:0] RIGHT_TARGET_RST = 16'd65534;

  // exp(-1/64) in Q0.32.
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380000;

  // One step of the Q32 decay recurrence, evaluated only at elaboration.
  function automatic logic [63:0] exp_next(input logic [63:0] r);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = (r >> 16) * EXP_STEP_Q32;
    lo = ((r & 64'hFFFF) * EXP_STEP_Q32) >> 16;
    return (hi + lo + 64'd32768) >> 16;
  endfunction

endpackage

`default_nettype wire

[rtl/metropolis_particle_walk_1d.sv]
// ---------------------------------------------------------------------------
// metropolis_particle_walk_1d
// Metropolis moves of particles on a stored 1-D energy landscape.
// ---------------------------------------------------------------------------
// One word is taken at a time and gives one result word. A load or a place
// goes from acceptance straight to S_FINISH, and so does any command for a
// particle index outside the particle store. A read passes S_PREAD and then
// S_FINISH, and so does a step refused because its neighbour lies outside
// the landscape. Any other step adds S_EREAD. The step walks the particle
// memory read, the two-port landscape read of the current and the neighbour
// energy, the registered read of the exp table, and the write-back into the
// particle memory, in that order. A result waits in the output register
// while the next word is accepted. If that register is still full when the
// next result is ready, the block holds in its last cycle until the receiver
// takes the word. All stores power up undefined; a particle must be placed
// and a landscape entry loaded before either is used.
`default_nettype none

`include "metropolis_particle_walk_1d_defines.svh"

module metropolis_particle_walk_1d #(
  parameter int LANDSCAPE_DEPTH = mpw1d_pkg::LANDSCAPE_DEPTH_DEF,
  parameter int PARTICLE_COUNT  = mpw1d_pkg::PARTICLE_COUNT_DEF,
  parameter int ENERGY_WIDTH    = mpw1d_pkg::ENERGY_WIDTH_DEF,
  parameter int EXP_TABLE_DEPTH = mpw1d_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // Command stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // landscape_address, energy_value, particle_index, start_position,
  // step_up, uniform_value, zero pad
  input  wire logic [79:0] s_tdata,
  // command
  input  wire logic [1:0]  s_tuser,
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // position, displacement, moved, zero pad
  output logic [55:0]      m_tdata,
  // status
  output logic [0:0]       m_tuser
);

  localparam int LAND_W = $clog2(LANDSCAPE_DEPTH);
  localparam int PIDX_W = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
  localparam int TAB_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int DE_W   = ENERGY_WIDTH + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PREAD  = 2'd1;
  localparam logic [1:0] S_EREAD  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  // Acceptance threshold table, exp(-k/64) in Q0.16, built at elaboration.
  typedef logic [15:0] exp_rom_t [EXP_TABLE_DEPTH];

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] r;
    logic [63:0] v;
    r = 64'h1_0000_0000;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      v = (r + 64'd32768) >> 16;
      rom[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      r = mpw1d_pkg::exp_next(r);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  // Input word fields.
  logic [1:0]         command;
  logic [15:0]        landscape_address;
  logic signed [15:0] energy_value;
  logic [9:0]         particle_index;
  logic [15:0]        start_position;
  logic               step_up;
  logic [15:0]        uniform_value;

  assign command           = s_tuser;
  assign landscape_address = s_tdata[15:0];
  assign energy_value      = s_tdata[31:16];
  assign particle_index    = s_tdata[41:32];
  assign start_position    = s_tdata[57:42];
  assign step_up           = s_tdata[58];
  assign uniform_value     = s_tdata[74:59];

  // Storage: the landscape, and one word per particle that holds the start,
  // unwrapped and wrapped positions from the top bits down.
  logic signed [ENERGY_WIDTH-1:0] energy_mem   [LANDSCAPE_DEPTH];
  logic [63:0]                    particle_mem [PARTICLE_COUNT];

  // Control and captured command.
  logic [1:0]        state;
  logic [1:0]        cmd_q;
  logic              perr_q;
  logic              nerr_q;
  logic              up_q;
  logic [15:0]       u_q;
  logic [15:0]       startp_q;
  logic [PIDX_W-1:0] pidx_q;

  // Memory read data and derived values.
  logic [15:0]                    wr_q;
  logic [31:0]                    un_q;
  logic [15:0]                    st_q;
  logic [31:0]                    disp_base_q;
  logic signed [ENERGY_WIDTH-1:0] e_cur_q;
  logic signed [ENERGY_WIDTH-1:0] e_nb_q;
  logic [15:0]                    exp_q;
  logic                           de_le0_q;
  logic                           in_tab_q;

  logic [15:0] left_edge;
  logic [15:0] left_target;
  logic [15:0] right_edge;
  logic [15:0] right_target;

  logic [15:0] out_position;
  logic [31:0] out_displacement;
  logic        out_moved;
  logic        out_status;

  logic s_fire;
  logic out_free;
  logic finish_fire;

  assign s_tready    = (state == S_IDLE);
  assign s_fire      = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign finish_fire = (state == S_FINISH) && out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge    <= mpw1d_pkg::LEFT_EDGE_RST;
      left_target  <= mpw1d_pkg::LEFT_TARGET_RST;
      right_edge   <= mpw1d_pkg::RIGHT_EDGE_RST;
      right_target <= mpw1d_pkg::RIGHT_TARGET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpw1d_pkg::REG_LEFT_EDGE:    left_edge    <= cfg_wdata;
        mpw1d_pkg::REG_LEFT_TARGET:  left_target  <= cfg_wdata;
        mpw1d_pkg::REG_RIGHT_EDGE:   right_edge   <= cfg_wdata;
        mpw1d_pkg::REG_RIGHT_TARGET: right_target <= cfg_wdata;
      endcase
    end
  end

  // Accept-time decode.
  logic              perr_in;
  logic              addr_ok;
  logic [PIDX_W-1:0] pidx_in;

  assign perr_in = 32'(particle_index) >= 32'(PARTICLE_COUNT);
  assign addr_ok = 32'(landscape_address) < 32'(LANDSCAPE_DEPTH);
  assign pidx_in = PIDX_W'(particle_index);

  // Neighbour of the current position and its range check.
  logic [16:0]       nb;
  logic              nerr;
  logic [LAND_W-1:0] cur_addr;
  logic [LAND_W-1:0] nb_addr;

  assign nb = up_q ? ({1'b0, wr_q} + 17'd1) : ({1'b0, wr_q} - 17'd1);
  assign nerr = (32'(wr_q) >= 32'(LANDSCAPE_DEPTH)) ||
                (!up_q && (wr_q == 16'd0)) ||
                (up_q && ((32'(wr_q) + 32'd1) >= 32'(LANDSCAPE_DEPTH)));
  assign cur_addr = LAND_W'(wr_q);
  assign nb_addr  = LAND_W'(nb);

  // Energy difference and the table lookup index.
  logic signed [DE_W-1:0] de;
  logic [DE_W-6:0]        de_idx;
  logic                   de_le0;
  logic                   in_tab;
  logic [TAB_W-1:0]       rom_addr;

  assign de       = DE_W'(e_nb_q) - DE_W'(e_cur_q);
  assign de_idx   = de[DE_W-2:4];
  assign de_le0   = de[DE_W-1] || (de == '0);
  assign in_tab   = !de[DE_W-1] && (32'(de_idx) < 32'(EXP_TABLE_DEPTH));
  assign rom_addr = in_tab ? TAB_W'(de_idx) : '0;

  // Landscape memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (s_fire && (command == mpw1d_pkg::CMD_LOAD) && addr_ok) begin
      energy_mem[LAND_W'(landscape_address)] <= ENERGY_WIDTH'(energy_value);
    end
    if ((state == S_PREAD) && !nerr) begin
      e_cur_q <= energy_mem[cur_addr];
      e_nb_q  <= energy_mem[nb_addr];
    end
  end

  // Exp table read.
  always_ff @(posedge clk) begin
    if (state == S_EREAD) begin
      exp_q    <= EXP_ROM[rom_addr];
      de_le0_q <= de_le0;
      in_tab_q <= in_tab;
    end
  end

  // Step outcome, evaluated in the finish cycle.
  logic        accept;
  logic [15:0] w_move;
  logic [15:0] w_acc;
  logic [15:0] w_left;
  logic [15:0] w_new;
  logic [31:0] un_new;
  logic [31:0] disp_new;
  logic        step_wb;

  assign accept   = de_le0_q || (in_tab_q && (u_q < exp_q));
  assign w_move   = up_q ? (wr_q + 16'd1) : (wr_q - 16'd1);
  assign w_acc    = accept ? w_move : wr_q;
  assign w_left   = (w_acc == left_edge) ? left_target : w_acc;
  assign w_new    = (w_left == right_edge) ? right_target : w_left;
  assign un_new   = !accept ? un_q : (up_q ? (un_q + 32'd1) : (un_q - 32'd1));
  assign disp_new = !accept ? disp_base_q
                            : (up_q ? (disp_base_q + 32'd1) : (disp_base_q - 32'd1));
  assign step_wb  = finish_fire && (cmd_q == mpw1d_pkg::CMD_STEP) && !perr_q && !nerr_q;

  // Particle memory: place at acceptance, step write-back at finish.
  always_ff @(posedge clk) begin
    if (s_fire && (command == mpw1d_pkg::CMD_PLACE) && !perr_in) begin
      particle_mem[pidx_in] <= {start_position, 32'(start_position), start_position};
    end else if (step_wb) begin
      particle_mem[pidx_q] <= {st_q, un_new, w_new};
    end
    if (s_fire && !perr_in) begin
      {st_q, un_q, wr_q} <= particle_mem[pidx_in];
    end
  end

  // Command capture and per-step flags.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      cmd_q    <= command;
      perr_q   <= perr_in;
      up_q     <= step_up;
      u_q      <= uniform_value;
      startp_q <= start_position;
      pidx_q   <= pidx_in;
    end
    if (state == S_PREAD) begin
      nerr_q      <= nerr;
      disp_base_q <= un_q - 32'(st_q);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            if ((command == mpw1d_pkg::CMD_LOAD) || (command == mpw1d_pkg::CMD_PLACE) ||
                perr_in) begin
              state <= S_FINISH;
            end else begin
              state <= S_PREAD;
            end
          end
        end
        S_PREAD: begin
          if ((cmd_q == mpw1d_pkg::CMD_STEP) && !nerr) begin
            state <= S_EREAD;
          end else begin
            state <= S_FINISH;
          end
        end
        S_EREAD: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      priority if (cmd_q == mpw1d_pkg::CMD_LOAD) begin
        out_position     <= 16'd0;
        out_displacement <= 32'd0;
        out_moved        <= 1'b0;
        out_status       <= 1'b0;
      end else if (perr_q) begin
        out_position     <= 16'd0;
        out_displacement <= 32'd0;
        out_moved        <= 1'b0;
        out_status       <= 1'b1;
      end else if (cmd_q == mpw1d_pkg::CMD_PLACE) begin
        out_position     <= startp_q;
        out_displacement <= 32'd0;
        out_moved        <= 1'b0;
        out_status       <= 1'b0;
      end else if ((cmd_q == mpw1d_pkg::CMD_READ) || nerr_q) begin
        out_position     <= wr_q;
        out_displacement <= disp_base_q;
        out_moved        <= 1'b0;
        out_status       <= nerr_q && (cmd_q == mpw1d_pkg::CMD_STEP);
      end else begin
        out_position     <= w_new;
        out_displacement <= disp_new;
        out_moved        <= accept;
        out_status       <= 1'b0;
      end
    end
  end

  assign m_tdata = {7'd0, out_moved, out_displacement, out_position};
  assign m_tuser = out_status;

  // Checks.
  `MPW1D_ASSERT(a_accept_leaves_idle, s_fire |=> (state != S_IDLE),
                "accepted word did not start processing")
  `MPW1D_ASSERT(a_finish_holds, (state == S_FINISH) && m_tvalid && !m_tready |=>
                (state == S_FINISH), "result left finish while output was full")
  `MPW1D_ASSERT(a_finish_emits, finish_fire |=> m_tvalid && (state == S_IDLE),
                "finish did not deliver a result")
  `MPW1D_ASSERT(a_moved_is_ok, m_tvalid |-> !(m_tdata[48] && m_tuser[0]),
                "moved flag set on an error result")

endmodule

`default_nettype wire
